// ===== src/r2fft_pkg.sv =====
// Shared constants, types and functions of the radix-2 FFT block.
package r2fft_pkg;

  localparam int DefMaxPoints   = 64;
  localparam int DefTwiddleBits = 16;
  localparam int DataW          = 24;
  localparam int SampleW        = 16;
  localparam int TableLog       = 6;
  localparam int TableFrac      = 22;
  localparam int CfgAddrW       = 3;
  localparam int CfgDataW       = 32;

  localparam logic [0:0] REG_LOG2_POINTS  = 1'b0;
  localparam logic [0:0] REG_INVERSE_MODE = 1'b1;

  localparam logic signed [31:0] VAL_MAX = 32'sd8388607;
  localparam logic signed [31:0] VAL_MIN = -32'sd8388608;

  typedef logic signed [DataW-1:0] data_t;

  localparam logic signed [31:0] QCOS [17] = '{
    32'sd4194304, 32'sd4174107, 32'sd4113712, 32'sd4013699, 32'sd3875032,
    32'sd3699046, 32'sd3487436, 32'sd3242241, 32'sd2965821, 32'sd2660838,
    32'sd2330230, 32'sd1977181, 32'sd1605091, 32'sd1217542, 32'sd818268,
    32'sd411114, 32'sd0
  };

  function automatic logic signed [31:0] twiddle(logic [TableLog-1:0] t, int tb);
    logic [1:0] q;
    logic [4:0] idx;
    logic signed [31:0] mag;
    int sh;
    q   = t[5:4];
    idx = q[0] ? (5'd16 - {1'b0, t[3:0]}) : {1'b0, t[3:0]};
    mag = QCOS[idx];
    sh  = TableFrac - (tb - 2);
    if (sh > 0) begin
      mag = (mag + (32'sd1 <<< (sh - 1))) >>> sh;
    end
    return (q == 2'd1 || q == 2'd2) ? -mag : mag;
  endfunction

  function automatic data_t sat24(logic signed [31:0] x);
    if (x > VAL_MAX) begin
      return data_t'(VAL_MAX);
    end else if (x < VAL_MIN) begin
      return data_t'(VAL_MIN);
    end
    return data_t'(x);
  endfunction

endpackage

// ===== src/r2fft_if.sv =====
// Sample and result channel interfaces.
interface r2fft_sample_if;
  logic                       valid;
  logic                       ready;
  logic signed [15:0]         sample_real;
  logic signed [15:0]         sample_imag;
  logic                       sample_last;
  modport source (output valid, sample_real, sample_imag, sample_last, input ready);
  modport sink (input valid, sample_real, sample_imag, sample_last, output ready);
endinterface

interface r2fft_result_if;
  logic                       valid;
  logic                       ready;
  logic signed [23:0]         result_real;
  logic signed [23:0]         result_imag;
  logic                       result_last;
  logic                       size_error;
  modport source (output valid, result_real, result_imag, result_last, size_error,
                  input ready);
  modport sink (input valid, result_real, result_imag, result_last, size_error,
                output ready);
endinterface

// ===== src/radix2_fft_with_inverse.sv =====
// Radix-2 decimation-in-time FFT top level with load, butterfly and unload sequencer.
// Samples load at one per cycle, unless a size_error result is still waiting, into a work
// RAM in arrival order until one marked last; the set is zero-padded to 2^k points, then
// the (n/2)*k butterflies run on the single RAM read port and write port, addressing the
// RAM through bit-reversed indices, and the n results are unloaded, each held until taken.
// A set larger than n is dropped and answered with one result flagged size_error.
// Inverse mode reads bin (n-i) mod n and shifts it right by k.
module radix2_fft_with_inverse
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS   = DefMaxPoints,
  parameter int TWIDDLE_BITS = DefTwiddleBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  r2fft_sample_if.sink        samples,
  r2fft_result_if.source      results
);
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int TB  = TWIDDLE_BITS;
  localparam int F   = TB - 2;
  localparam int PRW = TB + DataW;
  localparam int SW  = PRW + 1;
  localparam int BW  = SW - F;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PAD   = 4'd1;
  localparam logic [3:0] S_RD_E  = 4'd2;
  localparam logic [3:0] S_RD_O  = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_WR_E  = 4'd7;
  localparam logic [3:0] S_WR_O  = 4'd8;
  localparam logic [3:0] S_OUT_R = 4'd9;
  localparam logic [3:0] S_OUT_L = 4'd10;
  localparam logic [3:0] S_OUT_H = 4'd11;

  function automatic logic [AW-1:0] bitrev(logic [AW-1:0] x, logic [2:0] k);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) begin
      r[b] = x[AW-1-b];
    end
    return r >> (3'(AW) - k);
  endfunction

  logic [2:0]  log2_points;
  logic        inverse_mode;
  logic [3:0]  state;
  logic [6:0]  cnt;
  logic [AW:0] pad_ptr;
  logic [2:0]  run_k;
  logic [2:0]  stage;
  logic [AW-1:0] bf;
  logic [AW-1:0] oi;
  data_t er, ei, ore, oim;
  logic signed [PRW-1:0] p1, p2, p3, p4;
  logic signed [BW-1:0]  pr, pim;

  logic          out_valid;
  data_t         out_real, out_imag;
  logic          out_last, out_err;

  logic [2:0]    keff;
  logic [AW:0]   n, run_n;
  logic [6:0]    cnt_inc;
  logic          in_fire;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [2*DataW-1:0] wdata, rdata;
  logic [AW-1:0] hm, ival, ea, oa, src;
  logic [TableLog-1:0] tw_idx;
  logic signed [TB-1:0] tc, ts;
  logic signed [SW-1:0] sum_r, sum_i;
  data_t rd_re, rd_im;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INVERSE_MODE) ? CfgDataW'(inverse_mode)
                                                 : CfgDataW'(log2_points);

  assign keff    = (log2_points > 3'(AW)) ? 3'(AW) : log2_points;
  assign n       = (AW+1)'(1) << keff;
  assign run_n   = (AW+1)'(1) << run_k;
  assign cnt_inc = (cnt == 7'd127) ? cnt : cnt + 7'd1;
  assign samples.ready = (state == S_IDLE) && !out_valid;
  assign in_fire = samples.valid && samples.ready;

  assign hm     = AW'((AW+1)'(1) << (stage - 3'd1)) - AW'(1);
  assign ival   = bf & hm;
  assign ea     = AW'({bf & ~hm, 1'b0}) | ival;
  assign oa     = ea | (hm + AW'(1));
  assign tw_idx = TableLog'(32'(ival) << (3'(TableLog) - stage));
  assign tc     = TB'(twiddle(tw_idx, TB));
  assign ts     = TB'(twiddle(tw_idx + TableLog'(48), TB));
  assign src    = (AW'(0) - oi) & AW'(run_n - (AW+1)'(1));
  assign rd_re  = data_t'(rdata[2*DataW-1:DataW]);
  assign rd_im  = data_t'(rdata[DataW-1:0]);
  assign sum_r  = SW'(p1) - SW'(p2) + (SW'(1) <<< (F - 1));
  assign sum_i  = SW'(p3) + SW'(p4) + (SW'(1) <<< (F - 1));

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        we    = in_fire && (cnt < 7'(n));
        waddr = AW'(cnt);
        wdata = {DataW'(samples.sample_real), DataW'(samples.sample_imag)};
      end
      S_PAD: begin
        we    = (pad_ptr != run_n);
        waddr = AW'(pad_ptr);
      end
      S_RD_E: raddr = bitrev(ea, run_k);
      S_RD_O, S_MUL1, S_MUL2, S_SUM: raddr = bitrev(oa, run_k);
      S_WR_E: begin
        we    = 1'b1;
        waddr = bitrev(ea, run_k);
        wdata = {sat24(32'(er) + 32'(pr)), sat24(32'(ei) + 32'(pim))};
      end
      S_WR_O: begin
        we    = 1'b1;
        waddr = bitrev(oa, run_k);
        wdata = {sat24(32'(er) - 32'(pr)), sat24(32'(ei) - 32'(pim))};
      end
      S_OUT_R, S_OUT_L, S_OUT_H: raddr = bitrev(inverse_mode ? src : oi, run_k);
      default: ;
    endcase
  end

  r2fft_ram #(.WIDTH(2*DataW), .DEPTH(MAX_POINTS)) u_work (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_points  <= 3'd6;
      inverse_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_LOG2_POINTS) begin
        log2_points <= pwdata[2:0];
      end else begin
        inverse_mode <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cnt <= cnt_inc;
            if (samples.sample_last) begin
              cnt <= '0;
              if (cnt_inc > 7'(n)) begin
                out_valid <= 1'b1;
                out_real  <= '0;
                out_imag  <= '0;
                out_last  <= 1'b1;
                out_err   <= 1'b1;
              end else begin
                pad_ptr <= (AW+1)'(cnt_inc);
                run_k   <= keff;
                state   <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          if (pad_ptr == run_n) begin
            stage <= 3'd1;
            bf    <= '0;
            oi    <= '0;
            state <= (run_k == 3'd0) ? S_OUT_R : S_RD_E;
          end else begin
            pad_ptr <= pad_ptr + (AW+1)'(1);
          end
        end
        S_RD_E: state <= S_RD_O;
        S_RD_O: begin
          er    <= rd_re;
          ei    <= rd_im;
          state <= S_MUL1;
        end
        S_MUL1: begin
          ore   <= rd_re;
          oim   <= rd_im;
          p1    <= tc * rd_re;
          p2    <= ts * rd_im;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p3    <= tc * oim;
          p4    <= ts * ore;
          state <= S_SUM;
        end
        S_SUM: begin
          pr    <= BW'(sum_r >>> F);
          pim   <= BW'(sum_i >>> F);
          state <= S_WR_E;
        end
        S_WR_E: state <= S_WR_O;
        S_WR_O: begin
          if ((AW+1)'(bf) == (run_n >> 1) - (AW+1)'(1)) begin
            bf <= '0;
            if (stage == run_k) begin
              state <= S_OUT_R;
            end else begin
              stage <= stage + 3'd1;
              state <= S_RD_E;
            end
          end else begin
            bf    <= bf + AW'(1);
            state <= S_RD_E;
          end
        end
        S_OUT_R: state <= S_OUT_L;
        S_OUT_L: begin
          out_valid <= 1'b1;
          out_real  <= inverse_mode ? (rd_re >>> run_k) : rd_re;
          out_imag  <= inverse_mode ? (rd_im >>> run_k) : rd_im;
          out_last  <= ((AW+1)'(oi) == run_n - (AW+1)'(1));
          out_err   <= 1'b0;
          state     <= S_OUT_H;
        end
        S_OUT_H: begin
          if (results.ready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              oi    <= oi + AW'(1);
              state <= S_OUT_R;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid       = out_valid;
  assign results.result_real = out_real;
  assign results.result_imag = out_imag;
  assign results.result_last = out_last;
  assign results.size_error  = out_err;

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_last)
    else $error("size error result without last flag");

  a_no_write_unload: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_R || state == S_OUT_L || state == S_OUT_H) |-> !we)
    else $error("work RAM written during unload");

  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_E || state == S_WR_O) |-> (stage >= 3'd1 && stage <= run_k))
    else $error("butterfly stage out of range");

  a_unload_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT_L |=> out_valid && !out_err)
    else $error("unload beat not presented");
endmodule

// ===== src/r2fft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module r2fft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== test/radix2_fft_with_inverse_test.sv =====
// Testbench for the radix-2 FFT block: APB setup, random sample sets, bin-by-bin compare.
`timescale 1ns / 100ps
module radix2_fft_with_inverse_test;
  import r2fft_pkg::*;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } sample_t;

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               last;
    logic               err;
  } bin_t;

  localparam int WatchdogLimit = 40000;

  localparam int CosQ22 [17] = '{
    4194304, 4174107, 4113712, 4013699, 3875032, 3699046, 3487436, 3242241,
    2965821, 2660838, 2330230, 1977181, 1605091, 1217542, 818268, 411114, 0
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  r2fft_sample_if samples ();
  r2fft_result_if results ();

  radix2_fft_with_inverse uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .samples(samples.sink), .results(results.source)
  );

  sample_t pending_samples[$];
  bin_t    expected_bins[$];
  int      fail_count = 0;
  int      idle_cycles = 0;
  int      send_gap = 0;
  int      stall_left = 0;
  bit      sample_taken = 1'b0;

  int unsigned cur_log2 = 6;
  bit          cur_inverse = 0;
  longint      work_re[64];
  longint      work_im[64];
  int unsigned set_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint asr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clip24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic longint cos_fix(int unsigned t);
    int unsigned q;
    int unsigned r;
    longint mag;
    t = t & 63;
    q = t >> 4;
    r = t & 15;
    mag = CosQ22[(q & 1) ? 16 - r : r];
    mag = (mag + (64'sd1 <<< 7)) >>> 8;
    return (q == 1 || q == 2) ? -mag : mag;
  endfunction

  function automatic int unsigned effective_log2();
    return (cur_log2 > 6) ? 6 : cur_log2;
  endfunction

  task automatic predict_sample(sample_t s);
    int unsigned k;
    int unsigned n;
    int unsigned rev;
    int unsigned len;
    int unsigned e;
    int unsigned o;
    longint tr[64];
    longint ti[64];
    longint c;
    longint sn;
    longint pr;
    longint pim;
    longint er;
    longint ei;
    bin_t b;
    k = effective_log2();
    n = 1 << k;
    if (set_count < n) begin
      work_re[set_count] = 64'(s.re);
      work_im[set_count] = 64'(s.im);
    end
    if (set_count < 127) set_count++;
    if (!s.last) return;
    if (set_count > n) begin
      set_count = 0;
      b = '{re: 0, im: 0, last: 1'b1, err: 1'b1};
      expected_bins.push_back(b);
      return;
    end
    for (int i = set_count; i < n; i++) begin
      work_re[i] = 0;
      work_im[i] = 0;
    end
    set_count = 0;
    for (int i = 0; i < n; i++) begin
      rev = 0;
      for (int j = 0; j < k; j++) if (i & (1 << j)) rev |= 1 << (k - 1 - j);
      tr[rev] = work_re[i];
      ti[rev] = work_im[i];
    end
    for (len = 2; len <= n; len <<= 1) begin
      for (int base = 0; base < n; base += len) begin
        for (int i = 0; i < len / 2; i++) begin
          e = base + i;
          o = e + len / 2;
          c = cos_fix(i * (64 / len));
          sn = cos_fix(i * (64 / len) + 48);
          pr = asr(c * tr[o] - sn * ti[o] + 8192, 14);
          pim = asr(c * ti[o] + sn * tr[o] + 8192, 14);
          er = tr[e];
          ei = ti[e];
          tr[e] = clip24(er + pr);
          ti[e] = clip24(ei + pim);
          tr[o] = clip24(er - pr);
          ti[o] = clip24(ei - pim);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      o = cur_inverse ? ((n - i) & (n - 1)) : i;
      b.re = 24'(cur_inverse ? asr(tr[o], k) : tr[o]);
      b.im = 24'(cur_inverse ? asr(ti[o], k) : ti[o]);
      b.last = (i == n - 1);
      b.err = 1'b0;
      expected_bins.push_back(b);
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else if (sample_taken) begin
      send_gap = draw_gap();
      if (send_gap == 0 && pending_samples.size() > 0) begin
        samples.sample_real <= pending_samples[0].re;
        samples.sample_imag <= pending_samples[0].im;
        samples.sample_last <= pending_samples[0].last;
        samples.valid <= 1'b1;
        void'(pending_samples.pop_front());
      end else begin
        samples.valid <= 1'b0;
      end
    end else if (!samples.valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_samples.size() > 0) begin
        samples.sample_real <= pending_samples[0].re;
        samples.sample_imag <= pending_samples[0].im;
        samples.sample_last <= pending_samples[0].last;
        samples.valid <= 1'b1;
        void'(pending_samples.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      results.ready <= 1'b0;
    end else begin
      stall_left = draw_gap();
      results.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    bin_t exp_bin;
    sample_taken = !rst && samples.valid && samples.ready;
    if (!rst && samples.valid && samples.ready) predict_sample('{
        re: samples.sample_real, im: samples.sample_imag, last: samples.sample_last});
    if (!rst && results.valid && results.ready) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected result beat re=%0d im=%0d", results.result_real,
               results.result_imag);
        fail_count++;
      end else begin
        exp_bin = expected_bins.pop_front();
        if (results.result_real !== exp_bin.re) begin
          $error("result_real expected %0d got %0d", exp_bin.re, results.result_real);
          fail_count++;
        end
        if (results.result_imag !== exp_bin.im) begin
          $error("result_imag expected %0d got %0d", exp_bin.im, results.result_imag);
          fail_count++;
        end
        if (results.result_last !== exp_bin.last) begin
          $error("result_last expected %0b got %0b", exp_bin.last, results.result_last);
          fail_count++;
        end
        if (results.size_error !== exp_bin.err) begin
          $error("size_error expected %0b got %0b", exp_bin.err, results.size_error);
          fail_count++;
        end
      end
    end
    if ((samples.valid && samples.ready) || (results.valid && results.ready)) begin
      idle_cycles = 0;
    end else if (!rst) begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, int unsigned value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrW'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_LOG2_POINTS) cur_log2 = value & 7;
    else cur_inverse = value[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || samples.valid || expected_bins.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r < 5) return 16'($urandom_range(0, 2047)) - 16'sd1024;
    return 16'($urandom);
  endfunction

  task automatic queue_set(int count);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      s.re = rand_val();
      s.im = rand_val();
      s.last = (i == count - 1);
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    int n;
    int sent;
    int set_len;
    sample_t s;
    samples.valid = 1'b0;
    samples.sample_real = '0;
    samples.sample_imag = '0;
    samples.sample_last = 1'b0;
    results.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    s = '{re: 16'sh7fff, im: 16'sh8000, last: 1'b0};
    pending_samples.push_back(s);
    s = '{re: 16'sh8000, im: 16'sh7fff, last: 1'b0};
    pending_samples.push_back(s);
    s = '{re: 16'sh7fff, im: 16'sh7fff, last: 1'b1};
    pending_samples.push_back(s);
    drain();
    write_reg(REG_LOG2_POINTS, 0);
    s = '{re: 16'sh8000, im: 16'sh7fff, last: 1'b1};
    pending_samples.push_back(s);
    queue_set(2);
    drain();
    write_reg(REG_LOG2_POINTS, 2);
    write_reg(REG_INVERSE_MODE, 1);
    for (int i = 0; i < 4; i++) begin
      s = '{re: 16'sh7fff, im: 16'sh8000, last: (i == 3)};
      pending_samples.push_back(s);
    end
    queue_set(6);
    drain();
    write_reg(REG_LOG2_POINTS, 7);
    queue_set(64);
    queue_set(3);
    drain();

    sent = 83;
    while (sent < 430) begin
      write_reg(REG_LOG2_POINTS, $urandom_range(0, 7));
      write_reg(REG_INVERSE_MODE, $urandom_range(0, 1));
      n = 1 << effective_log2();
      for (int j = 0; j < 3; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          set_len = n + $urandom_range(1, 4);
        end else begin
          set_len = $urandom_range(1, (n > 16 && $urandom_range(0, 2) != 0) ? 16 : n);
        end
        queue_set(set_len);
        sent += set_len;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
